// ===== design/ps2_mouse_packet_decoder_macros.svh =====
// Assertion macros shared by the mouse packet decoder modules.
// Requires clk and rst_n in the scope of each use.
`ifndef PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PMD_ASSERT(lbl, prop, msg)
`define PMD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/pmd_pkg.sv =====
// Shared types and constants of the PS/2 mouse packet decoder.
// No dependencies.
package pmd_pkg;

  localparam int QDEPTH = 2;
  localparam int NBTN   = 5;
  localparam int NPEND  = 9;

  typedef enum logic [1:0] {
    KIND_MOTION = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_SYNC   = 2'd2
  } pmd_kind_t;

  localparam logic [2:0] CODE_X     = 3'd0;
  localparam logic [2:0] CODE_Y     = 3'd1;
  localparam logic [2:0] CODE_WHEEL = 3'd2;
  localparam logic [2:0] CODE_SYNC  = 3'd0;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_FOUR   = 2'd1;
  localparam logic [1:0] CFG_EXTRA  = 2'd2;

  localparam int BIT_X    = 0;
  localparam int BIT_Y    = 1;
  localparam int BIT_W    = 2;
  localparam int BIT_BTN0 = 3;
  localparam int BIT_SYNC = 8;

  typedef struct packed {
    logic [9:0]      motion_x;
    logic [9:0]      motion_y;
    logic [3:0]      wheel;
    logic [NBTN-1:0] btn_now;
    logic [NBTN-1:0] changed;
  } pmd_pkt_t;

  function automatic logic [NPEND-1:0] pend_mask(input pmd_pkt_t p);
    pend_mask = {1'b1, p.changed, (p.wheel != 4'd0), (p.motion_y != 10'd0),
                 (p.motion_x != 10'd0)};
  endfunction

endpackage

// ===== design/pmd_front.sv =====
// Front end: configuration registers, byte framing and packet classification.
// Depends on pmd_pkg.
module pmd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic             cfg_wdata,
  input  logic             q_full,
  output logic             push,
  output pmd_pkg::pmd_pkt_t push_data
);
  import pmd_pkg::*;

  logic            en_r, four_r, xbtn_r;
  logic [1:0]      idx_r, idx_nxt;
  logic [7:0]      pb_r [3];
  logic [NBTN-1:0] btn_r, btn_nxt;

  logic            take, complete, ovf;
  logic [7:0]      flags, b1, b2;
  logic [NBTN-1:0] newb;
  logic [9:0]      x10, y10;
  logic [3:0]      wheel;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  always_comb begin
    take     = in_valid && in_ready && en_r && ((idx_r != 2'd0) || in_data_byte[3]);
    complete = four_r ? (idx_r == 2'd3) : (idx_r >= 2'd2);
    flags    = pb_r[0];
    b1       = pb_r[1];
    b2       = (idx_r == 2'd2) ? in_data_byte : pb_r[2];
    ovf      = |flags[7:6];
    newb     = {four_r && xbtn_r && in_data_byte[5],
                four_r && xbtn_r && in_data_byte[4], flags[2:0]};
    wheel    = four_r ? in_data_byte[3:0] : 4'd0;
    x10      = ovf ? 10'd0 : {flags[4], flags[4], b1};
    y10      = ovf ? 10'd0 : {flags[5], flags[5], b2};
    push_data.motion_x    = x10;
    push_data.motion_y    = ~y10 + 10'd1;
    push_data.wheel       = wheel;
    push_data.btn_now     = newb;
    push_data.changed     = newb ^ btn_r;
    push = take && complete && ((x10 != 10'd0) || (y10 != 10'd0) ||
           (wheel != 4'd0) || (push_data.changed != '0));
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = complete ? 2'd0 : idx_r + 2'd1;
    end
    btn_nxt = push ? newb : btn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      four_r <= 1'b0;
      xbtn_r <= 1'b0;
      idx_r  <= 2'd0;
      btn_r  <= '0;
    end else begin
      idx_r <= idx_nxt;
      btn_r <= btn_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE: en_r   <= cfg_wdata;
          CFG_FOUR:   four_r <= cfg_wdata;
          CFG_EXTRA:  xbtn_r <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (idx_r)
        2'd0:    pb_r[0] <= in_data_byte;
        2'd1:    pb_r[1] <= in_data_byte;
        2'd2:    pb_r[2] <= in_data_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pmd_fifo.sv =====
// Short queue of classified packets between front and back end.
// Depends on pmd_pkg and the assertion macro header.
`include "ps2_mouse_packet_decoder_macros.svh"
module pmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pmd_pkg::pmd_pkt_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output pmd_pkg::pmd_pkt_t q_data
);
  import pmd_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  pmd_pkt_t      mem_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  `PMD_ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into full queue")
  `PMD_ASSERT_NEVER(a_no_underflow, pop && !q_valid, "pop from empty queue")
  `PMD_ASSERT(a_count_range, cnt_r <= CW'(QDEPTH), "queue count out of range")

endmodule

// ===== design/pmd_back.sv =====
// Back end: walks one classified packet into its result items.
// Depends on pmd_pkg and the assertion macro header.
`include "ps2_mouse_packet_decoder_macros.svh"
module pmd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pmd_pkg::pmd_pkt_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [2:0]        out_event_code,
  output logic signed [9:0] out_event_value,
  output logic              out_last_of_packet
);
  import pmd_pkg::*;

  pmd_pkt_t         desc_r, desc_nxt;
  logic [NPEND-1:0] pend_r, pend_nxt, pend_left, sel;
  logic             issue;
  logic             out_valid_r, out_valid_nxt;
  pmd_kind_t        kind_r, kind_nxt;
  logic [2:0]       code_r, code_nxt;
  logic [9:0]       value_r, value_nxt;
  logic             last_r, last_nxt;

  always_comb begin
    sel       = pend_r & (~pend_r + NPEND'(1));
    issue     = (pend_r != '0) && (!out_valid_r || out_ready);
    pend_left = issue ? (pend_r & ~sel) : pend_r;
    pop       = q_valid && (pend_left == '0);
    pend_nxt  = pop ? pend_mask(q_data) : pend_left;
    desc_nxt  = pop ? q_data : desc_r;
    out_valid_nxt = issue || (out_valid_r && !out_ready);
  end

  always_comb begin
    kind_nxt  = kind_r;
    code_nxt  = code_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    if (issue) begin
      kind_nxt  = KIND_SYNC;
      code_nxt  = CODE_SYNC;
      value_nxt = 10'd0;
      last_nxt  = 1'b1;
      if (sel[BIT_X]) begin
        kind_nxt  = KIND_MOTION;
        code_nxt  = CODE_X;
        value_nxt = desc_r.motion_x;
        last_nxt  = 1'b0;
      end else if (sel[BIT_Y]) begin
        kind_nxt  = KIND_MOTION;
        code_nxt  = CODE_Y;
        value_nxt = desc_r.motion_y;
        last_nxt  = 1'b0;
      end else if (sel[BIT_W]) begin
        kind_nxt  = KIND_MOTION;
        code_nxt  = CODE_WHEEL;
        value_nxt = {{6{desc_r.wheel[3]}}, desc_r.wheel};
        last_nxt  = 1'b0;
      end else begin
        for (int b = 0; b < NBTN; b++) begin
          if (sel[BIT_BTN0 + b]) begin
            kind_nxt  = KIND_BUTTON;
            code_nxt  = 3'(b);
            value_nxt = {9'd0, desc_r.btn_now[b]};
            last_nxt  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r  <= desc_nxt;
    kind_r  <= kind_nxt;
    code_r  <= code_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_event_code     = code_r;
  assign out_event_value    = value_r;
  assign out_last_of_packet = last_r;

  `PMD_ASSERT(a_sync_closes, issue && sel[BIT_SYNC] |-> pend_left == '0, "sync not last")
  `PMD_ASSERT(a_pend_has_sync, pend_r != '0 |-> pend_r[BIT_SYNC], "run without sync")
  `PMD_ASSERT(a_stall_holds,
              out_valid_r && !out_ready && pend_r != '0 |=> pend_r == $past(pend_r),
              "pending run advanced under stall")

endmodule

// ===== design/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder. Bytes are framed into 3- or 4-byte packets; a
// completed packet that moves, scrolls or changes a button is queued (two
// deep) and then walked into result items: nonzero X, negated Y and wheel,
// changed buttons, and a closing sync item with last_of_packet set. A byte is
// accepted in any cycle the packet queue has room, so bytes stream at one per
// cycle; the back end issues one result item per cycle unless out_ready stalls
// it, and a packet yields two to nine result items. No clearing pass after
// reset. Configuration writes are taken every cycle.
// Depends on pmd_pkg, pmd_front, pmd_fifo and pmd_back.
module ps2_mouse_packet_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [2:0]        out_event_code,
  output logic signed [9:0] out_event_value,
  output logic              out_last_of_packet,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_wdata
);
  import pmd_pkg::*;

  logic     q_full, push, pop, q_valid;
  pmd_pkt_t push_data, q_data;

  pmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  pmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  pmd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_event_code     (out_event_code),
    .out_event_value    (out_event_value),
    .out_last_of_packet (out_last_of_packet)
  );

endmodule
